### hdl/fct_pkg.sv
package fct_pkg;

  // frustum geometry
  localparam int PLANE_COUNT  = 6;
  localparam int CORNER_COUNT = 8;
  localparam int COEF_COUNT   = 4 * PLANE_COUNT;
  localparam int REG_COUNT    = 8;

  // query kinds
  typedef enum logic [1:0] {
    MODE_POINT  = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_BOX    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // operations of the shared root / divide unit
  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } ds_op_e;

  typedef struct packed {
    logic   start;
    ds_op_e op;
  } ds_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_RUN,
    S_Q_DONE,
    S_B_START,
    S_B_SQ,
    S_B_SQRT_GO,
    S_B_SQRT_WAIT,
    S_B_DIV_GO,
    S_B_DIV_WAIT
  } state_e;

  // matrix held as four rows of 128 bits: row k = {reg 2k+1, reg 2k}
  localparam logic [127:0] MAT_RESET [4] = '{
    {64'h0, 64'h0000_0000_0001_0000},
    {64'h0, 64'h0001_0000_0000_0000},
    {64'h0000_0000_0001_0000, 64'h0},
    {64'h0001_0000_0000_0000, 64'h0}
  };

endpackage

### hdl/fct_if.sv
// query channel
interface fct_query_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] far_x;
  logic signed [31:0] far_y;
  logic signed [31:0] far_z;
  logic [30:0]        radius;

  modport source (output valid, mode, pos_x, pos_y, pos_z, far_x, far_y, far_z, radius,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, far_x, far_y, far_z, radius,
                output ready);
endinterface

// result channel
interface fct_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

### hdl/fct_mul.sv
module fct_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  // registered signed product
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### hdl/fct_divsqrt.sv
module fct_divsqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fct_pkg::ds_req_t req_i,
  input  logic [65:0]      rad_i,
  input  logic [48:0]      dvd_i,
  input  logic [32:0]      dvs_i,
  output logic             done_o,
  output logic [48:0]      res_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  fct_pkg::ds_op_e  op_q;
  logic [65:0]      src_q;
  logic [35:0]      rem_q;
  logic [48:0]      res_q;
  logic [32:0]      dvs_q;
  logic [36:0]      rem2;
  logic [36:0]      trial;
  logic [36:0]      diff;
  logic             geq;
  logic [5:0]       last;

  // one restoring step: root takes two radicand bits, divide takes one
  always_comb begin
    if (op_q == fct_pkg::OP_SQRT) begin
      rem2  = {rem_q[34:0], src_q[65:64]};
      trial = {2'b00, res_q[32:0], 2'b01};
      last  = 6'd32;
    end else begin
      rem2  = {rem_q, src_q[65]};
      trial = {4'b0000, dvs_q};
      last  = 6'd48;
    end
    geq  = (rem2 >= trial);
    diff = rem2 - trial;
  end

  // control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      src_q <= (req_i.op == fct_pkg::OP_SQRT) ? rad_i : {dvd_i, 17'b0};
      rem_q <= '0;
      res_q <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      src_q <= (op_q == fct_pkg::OP_SQRT) ? {src_q[63:0], 2'b00} : {src_q[64:0], 1'b0};
      rem_q <= geq ? diff[35:0] : rem2[35:0];
      res_q <= {res_q[47:0], geq};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/frustum_cull_test_core.sv
// Frustum cull test. Software writes a column-major 4x4 view-projection matrix (signed
// Q16.16) as eight 64-bit registers; after reset and after every register write the core
// extracts the six planes, normalizes each by the length of its normal and keeps the 24
// coefficients. This rebuild uses one shared root/divide unit (33 root steps, then four
// 49-step divides per plane); while it runs no query is taken. For a query (point, sphere
// or axis-aligned box) one shared 34x34 multiplier walks the 24 stored coefficients,
// one per cycle; for a box the corner farthest along each plane normal is picked per
// axis, so a box costs the same as a point. A finished result waits in an output
// register while the next query is accepted. Mode 3 always answers 0.
module frustum_cull_test_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  fct_query_if.sink     query_i,
  fct_result_if.source  result_o
);

  fct_pkg::state_e    state_q, state_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [2:0]         p_q, p_d;
  logic [1:0]         k_q, k_d;
  logic [65:0]        sum_q, sum_d;
  logic [32:0]        len_q, len_d;
  logic signed [67:0] acc_q, acc_d;
  logic               ok_q, ok_d;
  logic               vld_p_q;
  logic [1:0]         kp_q;
  logic               out_valid_q, out_valid_d;
  logic               out_res_q, out_res_d;
  logic [127:0]       mat_q [4];
  logic [31:0]        store_q [fct_pkg::COEF_COUNT];

  fct_pkg::mode_e     mode_q;
  logic signed [31:0] lo_q [3];
  logic signed [31:0] hi_q [3];
  logic [30:0]        radius_q;

  logic               accept;
  logic               in_ready;
  logic               adv;
  logic               issue;
  logic [1:0]         cidx;
  logic [127:0]       row;
  logic signed [31:0] w_ent, e_ent;
  logic signed [32:0] cval;
  logic [32:0]        cmag;
  logic [4:0]         qidx;
  logic signed [31:0] coef;
  logic signed [31:0] lo_c, hi_c, coord;
  logic               sel_hi;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [67:0] extra;
  logic signed [67:0] qsum;
  logic               pass;
  fct_pkg::ds_req_t   ds_req;
  logic               ds_done;
  logic [48:0]        ds_res;
  logic               store_we;
  logic [31:0]        store_wdata;
  logic [31:0]        sat;

  // plane coefficient k of plane p: w +/- e over matrix row k
  always_comb begin
    cidx  = (state_q == fct_pkg::S_B_SQ) ? cnt_q[1:0] : k_q;
    row   = mat_q[cidx];
    w_ent = row[127:96];
    case (p_q[2:1])
      2'd0:    e_ent = row[31:0];
      2'd1:    e_ent = row[63:32];
      default: e_ent = row[95:64];
    endcase
    cval = p_q[0] ? ({w_ent[31], w_ent} - {e_ent[31], e_ent})
                  : ({w_ent[31], w_ent} + {e_ent[31], e_ent});
    cmag = cval[32] ? 33'(-cval) : 33'(cval);
  end

  // query operand selection, box picks the corner farthest along the normal
  always_comb begin
    qidx  = (cnt_q < 5'(fct_pkg::COEF_COUNT)) ? cnt_q : '0;
    coef  = store_q[qidx];
    case (cnt_q[1:0])
      2'd0:    begin lo_c = lo_q[0]; hi_c = hi_q[0]; end
      2'd1:    begin lo_c = lo_q[1]; hi_c = hi_q[1]; end
      default: begin lo_c = lo_q[2]; hi_c = hi_q[2]; end
    endcase
    sel_hi = (mode_q == fct_pkg::MODE_BOX) && ((!coef[31]) == (hi_c >= lo_c));
    coord  = sel_hi ? hi_c : lo_c;
    if (state_q == fct_pkg::S_B_SQ) begin
      mul_a = {cval[32], cval};
      mul_b = {cval[32], cval};
    end else begin
      mul_a = {{2{coef[31]}}, coef};
      mul_b = (cnt_q[1:0] == 2'd3) ? 34'sd65536 : {{2{coord[31]}}, coord};
    end
  end

  fct_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  fct_divsqrt u_ds (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .rad_i  (sum_q),
    .dvd_i  ({cmag, 16'b0}),
    .dvs_i  (len_q),
    .done_o (ds_done),
    .res_o  (ds_res)
  );

  // plane distance accumulation
  always_comb begin
    issue = (state_q == fct_pkg::S_Q_RUN) && (cnt_q < 5'(fct_pkg::COEF_COUNT));
    extra = (kp_q == 2'd3 && mode_q == fct_pkg::MODE_SPHERE)
          ? {21'b0, radius_q, 16'b0} : '0;
    qsum  = ((kp_q == 2'd0) ? 68'sd0 : acc_q) + prod + extra;
    pass  = !qsum[67] && (qsum != 68'sd0);
  end

  // signed saturation of the normalized coefficient
  always_comb begin
    if (cval[32]) begin
      sat = (ds_res > 49'h0_8000_0000) ? 32'h8000_0000 : ds_res[31:0];
      sat = 32'(0) - sat;
    end else begin
      sat = (ds_res > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : ds_res[31:0];
    end
  end

  assign accept = query_i.valid && in_ready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    k_d         = k_q;
    sum_d       = sum_q;
    len_d       = len_q;
    acc_d       = acc_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    ds_req      = '{start: 1'b0, op: fct_pkg::OP_SQRT};
    store_we    = 1'b0;
    store_wdata = '0;
    in_ready    = 1'b0;
    adv         = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      fct_pkg::S_IDLE: begin
        in_ready = !cfg_we_i;
        if (accept) begin
          cnt_d   = '0;
          ok_d    = (fct_pkg::mode_e'(query_i.mode) != fct_pkg::MODE_NONE);
          state_d = fct_pkg::S_Q_RUN;
        end
      end
      fct_pkg::S_Q_RUN: begin
        cnt_d = cnt_q + 5'd1;
        if (vld_p_q) begin
          if (kp_q == 2'd3) begin
            ok_d = ok_q & pass;
          end else begin
            acc_d = qsum;
          end
        end
        if (cnt_q == 5'(fct_pkg::COEF_COUNT)) begin
          state_d = fct_pkg::S_Q_DONE;
        end
      end
      fct_pkg::S_Q_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = ok_q;
          state_d     = fct_pkg::S_IDLE;
        end
      end
      fct_pkg::S_B_START: begin
        p_d     = '0;
        cnt_d   = '0;
        state_d = fct_pkg::S_B_SQ;
      end
      fct_pkg::S_B_SQ: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q != 5'd0) begin
          sum_d = ((cnt_q == 5'd1) ? 66'd0 : sum_q) + prod[65:0];
        end
        if (cnt_q == 5'd3) begin
          state_d = fct_pkg::S_B_SQRT_GO;
        end
      end
      fct_pkg::S_B_SQRT_GO: begin
        ds_req  = '{start: 1'b1, op: fct_pkg::OP_SQRT};
        state_d = fct_pkg::S_B_SQRT_WAIT;
      end
      fct_pkg::S_B_SQRT_WAIT: begin
        if (ds_done) begin
          len_d   = ds_res[32:0];
          k_d     = '0;
          state_d = fct_pkg::S_B_DIV_GO;
        end
      end
      fct_pkg::S_B_DIV_GO: begin
        if (len_q == 33'd0) begin
          // zero normal: plane stored as all zeros
          store_we = 1'b1;
          adv      = 1'b1;
        end else begin
          ds_req  = '{start: 1'b1, op: fct_pkg::OP_DIV};
          state_d = fct_pkg::S_B_DIV_WAIT;
        end
      end
      fct_pkg::S_B_DIV_WAIT: begin
        if (ds_done) begin
          store_we    = 1'b1;
          store_wdata = sat;
          adv         = 1'b1;
        end
      end
      default: begin
        state_d = fct_pkg::S_IDLE;
      end
    endcase

    // next coefficient, next plane or done
    if (adv) begin
      if (k_q == 2'd3) begin
        if (p_q == 3'(fct_pkg::PLANE_COUNT - 1)) begin
          state_d = fct_pkg::S_IDLE;
        end else begin
          p_d     = p_q + 3'd1;
          cnt_d   = '0;
          state_d = fct_pkg::S_B_SQ;
        end
      end else begin
        k_d     = k_q + 2'd1;
        state_d = fct_pkg::S_B_DIV_GO;
      end
    end

    // a register write restarts the plane rebuild
    if (cfg_we_i) begin
      state_d = fct_pkg::S_B_START;
    end
  end

  // control registers and matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fct_pkg::S_B_START;
      cnt_q       <= '0;
      p_q         <= '0;
      k_q         <= '0;
      ok_q        <= 1'b0;
      vld_p_q     <= 1'b0;
      out_valid_q <= 1'b0;
      mat_q       <= fct_pkg::MAT_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p_q         <= p_d;
      k_q         <= k_d;
      ok_q        <= ok_d;
      vld_p_q     <= issue;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mat_q[cfg_idx_i[2:1]][64 * cfg_idx_i[0] +: 64] <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    len_q     <= len_d;
    acc_q     <= acc_d;
    kp_q      <= cnt_q[1:0];
    out_res_q <= out_res_d;
    if (store_we) begin
      store_q[{p_q, k_q}] <= store_wdata;
    end
    if (accept) begin
      mode_q   <= fct_pkg::mode_e'(query_i.mode);
      lo_q[0]  <= query_i.pos_x;
      lo_q[1]  <= query_i.pos_y;
      lo_q[2]  <= query_i.pos_z;
      hi_q[0]  <= query_i.far_x;
      hi_q[1]  <= query_i.far_y;
      hi_q[2]  <= query_i.far_z;
      radius_q <= query_i.radius;
    end
  end

  assign query_i.ready       = in_ready;
  assign result_o.valid      = out_valid_q;
  assign result_o.inside_res = out_res_q;

  // unused query kind never passes
  a_mode_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fct_pkg::S_Q_DONE && mode_q == fct_pkg::MODE_NONE) |-> !ok_q)
    else $error("mode 3 query reached done with a pass");

  // a register write always restarts the rebuild
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == fct_pkg::S_B_START)
    else $error("register write did not restart plane rebuild");

  // plane counter stays within the frustum
  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_q < 3'(fct_pkg::PLANE_COUNT))
    else $error("plane index out of range");

  // a result appears only when a query completes
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == fct_pkg::S_Q_DONE)
    else $error("result raised outside query completion");

endmodule
